### sv/rtti_pkg.sv
// shared types and constants for the radix text to integer block
// status codes, queue item format, character codes and config indexes
// no dependencies
package rtti_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_OVER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_OTHER = 2'd2
  } kind_e;

  // one classified character as it travels from front to back
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } item_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] CfgRadix  = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgSigned = 1'b1;

  localparam logic [4:0] RadixReset = 5'd10;
  localparam logic [4:0] RadixMin   = 5'd2;
  localparam logic [4:0] RadixMax   = 5'd16;

  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerF  = 8'h66;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] DigitTen    = 8'd10;

endpackage

### sv/rtti_front.sv
// front end: classifies each incoming character as digit, minus or other
// uses rtti_pkg for character codes and the item format
module rtti_front (
  input  logic [7:0]     ch_i,
  input  logic           end_of_text_i,
  input  logic [4:0]     radix_i,
  output rtti_pkg::item_t item_o
);

  logic [7:0] value;
  logic       is_char;
  logic       radix_ok;

  always_comb begin
    value   = 8'd0;
    is_char = 1'b1;
    if (ch_i >= rtti_pkg::CharZero && ch_i <= rtti_pkg::CharNine) begin
      value = ch_i - rtti_pkg::CharZero;
    end else if (ch_i >= rtti_pkg::CharLowerA && ch_i <= rtti_pkg::CharLowerF) begin
      value = ch_i - rtti_pkg::CharLowerA + rtti_pkg::DigitTen;
    end else if (ch_i >= rtti_pkg::CharUpperA && ch_i <= rtti_pkg::CharUpperF) begin
      value = ch_i - rtti_pkg::CharUpperA + rtti_pkg::DigitTen;
    end else begin
      is_char = 1'b0;
    end
  end

  assign radix_ok = (radix_i >= rtti_pkg::RadixMin) && (radix_i <= rtti_pkg::RadixMax);

  always_comb begin
    item_o.digit = value[3:0];
    if (end_of_text_i) begin
      item_o.kind = rtti_pkg::KIND_OTHER;
    end else if (is_char && radix_ok && ({3'b000, radix_i} > value)) begin
      item_o.kind = rtti_pkg::KIND_DIGIT;
    end else if (ch_i == rtti_pkg::CharMinus) begin
      item_o.kind = rtti_pkg::KIND_MINUS;
    end else begin
      item_o.kind = rtti_pkg::KIND_OTHER;
    end
  end

endmodule

### sv/rtti_queue.sv
// short queue of classified items between front and back
// uses rtti_pkg for the item format and the depth
module rtti_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rtti_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output rtti_pkg::item_t head_o
);

  localparam int unsigned PtrW = rtti_pkg::QueuePtrW;
  localparam int unsigned CntW = rtti_pkg::QueueCntW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rtti_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(rtti_pkg::QueueDepth);

  rtti_pkg::item_t entry_q [rtti_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### sv/rtti_back.sv
// back end: accumulates digits, checks limits and holds the result register
// uses rtti_pkg for the item format and status codes
module rtti_back #(
  parameter logic [15:0] CountCap = 16'hFFFF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      radix_i,
  input  logic            signed_mode_i,
  input  logic            head_valid_i,
  input  rtti_pkg::item_t head_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [63:0]     value_o,
  output logic [1:0]      status_o,
  output logic [15:0]     chars_consumed_o
);

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_MINUS  = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [15:0] cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q, value_d;
  rtti_pkg::status_e status_q, status_d;
  logic [15:0] chars_q, chars_d;

  logic [63:0] limit;
  logic [68:0] product;
  logic [68:0] sum;
  logic        digit_over;
  logic        end_over;
  logic [15:0] cnt_inc;
  logic        emit;
  rtti_pkg::status_e emit_status;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (neg_q) begin
      limit = {1'b1, 63'd0};
    end else if (signed_mode_i) begin
      limit = {1'b0, {63{1'b1}}};
    end else begin
      limit = {64{1'b1}};
    end
  end

  // acc * radix + d > limit is the same test as the divide-based check
  assign product    = {5'd0, acc_q} * {64'd0, radix_i};
  assign sum        = product + {65'd0, head_i.digit};
  assign digit_over = (sum > {5'd0, limit});
  assign end_over   = (acc_q > limit);
  assign cnt_inc    = (cnt_q < CountCap) ? cnt_q + 16'd1 : cnt_q;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    emit        = 1'b0;
    emit_status = rtti_pkg::ST_OK;

    if (pop_o) begin
      if (head_i.kind == rtti_pkg::KIND_MINUS && phase_q == PH_START && signed_mode_i) begin
        neg_d   = 1'b1;
        cnt_d   = cnt_inc;
        phase_d = PH_MINUS;
      end else if (head_i.kind == rtti_pkg::KIND_DIGIT) begin
        if (digit_over) begin
          emit        = 1'b1;
          emit_status = rtti_pkg::ST_OVER;
        end else begin
          acc_d   = sum[63:0];
          cnt_d   = cnt_inc;
          phase_d = PH_DIGITS;
        end
      end else begin
        emit = 1'b1;
        if (phase_q != PH_DIGITS) begin
          emit_status = rtti_pkg::ST_NONE;
        end else if (end_over) begin
          emit_status = rtti_pkg::ST_OVER;
        end else begin
          emit_status = rtti_pkg::ST_OK;
        end
      end
      if (emit) begin
        phase_d = PH_START;
        acc_d   = '0;
        cnt_d   = '0;
        neg_d   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    chars_d     = chars_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      status_d    = emit_status;
      chars_d     = cnt_q;
      if (emit_status != rtti_pkg::ST_OK) begin
        value_d = '0;
      end else if (neg_q) begin
        value_d = 64'd0 - acc_q;
      end else begin
        value_d = acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      acc_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= rtti_pkg::ST_OK;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    chars_q <= chars_d;
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign status_o         = status_q;
  assign chars_consumed_o = chars_q;

endmodule

### sv/radix_text_to_integer.sv
// Radix text to integer: takes one character (or an end-of-text mark) per item and
// builds a 64-bit integer in a radix from 2 to 16, one result per number with value,
// status and count of characters taken. Throughput is one item per cycle while no
// result waits on a stalled output; the back end folds one digit per cycle (multiply
// by radix, add, limit compare), and a result is loaded into the output register at
// the edge that pops its terminator, which is first written into the queue.
// A two-entry queue separates the classifying front end from the accumulator. While
// a result waits to be taken the back end holds, the queue takes up to two more
// items, and then the input stalls.
// Config writes are always accepted and take effect on the next cycle.
module radix_text_to_integer #(
  parameter int unsigned COUNT_LIMIT = 65535
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rtti_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [4:0]                       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       ch_i,
  input  logic                             end_of_text_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [63:0]                      value_o,
  output logic [1:0]                       status_o,
  output logic [15:0]                      chars_consumed_o
);

  localparam logic [15:0] CountCap =
    (COUNT_LIMIT < 32'd65535) ? 16'(COUNT_LIMIT) : 16'hFFFF;

  logic [4:0]      radix_q;
  logic            signed_mode_q;
  rtti_pkg::item_t front_item;
  rtti_pkg::item_t head_item;
  logic            queue_full;
  logic            head_valid;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= rtti_pkg::RadixReset;
      signed_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtti_pkg::CfgRadix:  radix_q       <= cfg_data_i;
        rtti_pkg::CfgSigned: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rtti_front u_front (
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .radix_i       (radix_q),
    .item_o        (front_item)
  );

  rtti_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_item_i  (front_item),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_item)
  );

  assign in_stall_o = queue_full;

  rtti_back #(
    .CountCap (CountCap)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .radix_i          (radix_q),
    .signed_mode_i    (signed_mode_q),
    .head_valid_i     (head_valid),
    .head_i           (head_item),
    .pop_o            (pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .value_o          (value_o),
    .status_o         (status_o),
    .chars_consumed_o (chars_consumed_o)
  );

`ifndef ASSERT_OFF
  // a failed number always reports zero
  a_fail_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rtti_pkg::ST_OK) |-> (value_o == 64'd0))
    else $error("non-ok result carries a nonzero value");

  // no digits means at most a minus sign was taken
  a_none_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rtti_pkg::ST_NONE) |-> (chars_consumed_o <= 16'd1))
    else $error("no-digit result with more than one character consumed");

  // an ok number took at least one digit
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rtti_pkg::ST_OK) |-> (chars_consumed_o != 16'd0))
    else $error("ok result with no characters consumed");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule
